>>> hw/rtl/lpcd_pkg.sv
// shared types and constants for the length-prefixed command deframer
// no dependencies; imported by lpcd_core, length_prefixed_command_deframer and the testbench
package lpcd_pkg;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 16;
    localparam int ACC_W    = 17;
    localparam int CODE_W   = 2;
    localparam int PTEXT_W  = 64;
    localparam int PCOUNT_W = 4;
    localparam int CIDX_W   = 2;
    localparam int MDATA_W  = 32;

    // register indexes on the configuration port
    localparam logic [CIDX_W-1:0] CFG_PREFIX_TEXT  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_PREFIX_COUNT = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_MAX_LENGTH   = 2'd2;

    localparam logic [PTEXT_W-1:0]  PREFIX_TEXT_RST  = 64'h434F_4D4D_414E_443A;
    localparam logic [PCOUNT_W-1:0] PREFIX_COUNT_RST = 4'd8;
    localparam logic [PCOUNT_W-1:0] PREFIX_COUNT_MAX = 4'd8;
    localparam logic [LEN_W-1:0]    MAX_LENGTH_RST   = 16'd4096;

    localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_CR   = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;

    localparam logic [ACC_W-1:0] LEN_SAT = 17'h1_FFFF;

    // error codes
    localparam logic [CODE_W-1:0] ERR_PREFIX = 2'd0;
    localparam logic [CODE_W-1:0] ERR_LINE   = 2'd1;
    localparam logic [CODE_W-1:0] ERR_RANGE  = 2'd2;
    localparam logic [CODE_W-1:0] ERR_SHORT  = 2'd3;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_ERROR   = 1'b1;

    typedef enum logic [1:0] {
        PH_PREFIX,
        PH_LINE,
        PH_PAYLOAD,
        PH_DISCARD
    } t_phase;

    typedef struct packed {
        logic [PTEXT_W-1:0]  prefix_text;
        logic [PCOUNT_W-1:0] prefix_count;
        logic [LEN_W-1:0]    max_length;
    } t_cfg;

    typedef struct packed {
        logic                out_kind;
        logic [BYTE_W-1:0]   payload_byte;
        logic                frame_last;
        logic [LEN_W-1:0]    payload_length;
        logic [CODE_W-1:0]   error_code;
    } t_result;

endpackage

>>> hw/rtl/lpcd_core.sv
// per-byte parse engine: request state and the result of one byte
// depends on lpcd_pkg
module lpcd_core #(
    parameter int LINE_CHARS_MAX = 31
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  lpcd_pkg::t_cfg          i_cfg,
    input  logic                    i_fire,
    input  logic [7:0]              i_byte,
    input  logic                    i_end,
    output logic                    o_res_valid,
    output lpcd_pkg::t_result       o_res
);
    import lpcd_pkg::*;

    localparam int LC_W = $clog2(LINE_CHARS_MAX + 1);

    t_phase               r_phase, n_phase;
    logic [PCOUNT_W-1:0]  r_pos, n_pos;
    logic [LC_W-1:0]      r_line_chars, n_line_chars;
    logic [ACC_W-1:0]     r_len, n_len;
    logic [LEN_W-1:0]     r_pcount, n_pcount;

    logic [PCOUNT_W-1:0]  w_count;
    t_phase               w_phase;
    logic [BYTE_W-1:0]    w_want;
    logic [PCOUNT_W-1:0]  w_pos_inc;
    logic                 w_prefix_done;
    logic                 w_eol;
    logic                 w_digit;
    logic [3:0]           w_digit_val;
    logic [ACC_W+3:0]     w_acc;
    logic                 w_len_bad;
    logic                 w_line_full;
    logic [LEN_W-1:0]     w_pcount_inc;
    logic                 w_frame_done;

    assign w_count = (i_cfg.prefix_count > PREFIX_COUNT_MAX) ? PREFIX_COUNT_MAX
                                                           : i_cfg.prefix_count;
    // prefix already complete (zero count or count lowered) means the line comes next
    assign w_phase = (r_phase == PH_PREFIX && r_pos >= w_count) ? PH_LINE : r_phase;
    // first character sits in the top byte
    assign w_want        = i_cfg.prefix_text[{~r_pos[2:0], 3'b000} +: BYTE_W];
    assign w_pos_inc     = r_pos + PCOUNT_W'(1);
    assign w_prefix_done = (w_pos_inc >= w_count);
    assign w_eol         = (i_byte == CHAR_LF) || (i_byte == CHAR_CR);
    assign w_digit       = (i_byte >= CHAR_ZERO) && (i_byte <= CHAR_NINE);
    // ascii digits sit at 0x30, so the low nibble is the digit value
    assign w_digit_val   = i_byte[3:0];
    // times ten as two shifts and an add
    assign w_acc = {r_len, 3'b000} + {2'b00, r_len, 1'b0} + {13'd0, w_digit_val};
    assign w_len_bad     = (r_len == '0) || (r_len >= {1'b0, i_cfg.max_length});
    assign w_line_full   = (r_line_chars >= LC_W'(LINE_CHARS_MAX));
    assign w_pcount_inc  = r_pcount + LEN_W'(1);
    assign w_frame_done  = ({1'b0, w_pcount_inc} >= r_len);

    // next state
    always_comb begin
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_line_chars = r_line_chars;
        n_len        = r_len;
        n_pcount     = r_pcount;
        if (i_fire) begin
            n_phase = w_phase;
            case (w_phase)
                PH_PREFIX: begin
                    if (i_byte != w_want) begin
                        n_phase = PH_DISCARD;
                    end else begin
                        n_pos = w_pos_inc;
                        if (w_prefix_done) begin
                            n_phase      = PH_LINE;
                            n_line_chars = '0;
                            n_len        = '0;
                        end
                    end
                end
                PH_LINE: begin
                    if (w_eol) begin
                        if (w_len_bad) begin
                            n_phase = PH_DISCARD;
                        end else begin
                            n_phase  = PH_PAYLOAD;
                            n_pcount = '0;
                        end
                    end else if (w_line_full) begin
                        n_phase = PH_DISCARD;
                    end else begin
                        n_line_chars = r_line_chars + LC_W'(1);
                        if (w_digit) begin
                            n_len = (w_acc > {4'd0, LEN_SAT}) ? LEN_SAT : w_acc[ACC_W-1:0];
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_pcount = w_pcount_inc;
                    if (w_frame_done) begin
                        n_phase = PH_DISCARD;
                    end
                end
                default: begin
                    n_phase = PH_DISCARD;
                end
            endcase
            if (i_end) begin
                n_phase      = PH_PREFIX;
                n_pos        = '0;
                n_line_chars = '0;
                n_len        = '0;
                n_pcount     = '0;
            end
        end
    end

    // result of the current byte
    always_comb begin
        o_res_valid          = 1'b0;
        o_res.out_kind       = KIND_ERROR;
        o_res.payload_byte   = '0;
        o_res.frame_last     = 1'b0;
        o_res.payload_length = '0;
        o_res.error_code     = ERR_PREFIX;
        if (i_fire) begin
            case (w_phase)
                PH_PREFIX: begin
                    if (i_byte != w_want || (!w_prefix_done && i_end)) begin
                        o_res_valid      = 1'b1;
                        o_res.error_code = ERR_PREFIX;
                    end
                end
                PH_LINE: begin
                    if (w_eol) begin
                        if (w_len_bad) begin
                            o_res_valid      = 1'b1;
                            o_res.error_code = ERR_RANGE;
                        end else if (i_end) begin
                            o_res_valid      = 1'b1;
                            o_res.error_code = ERR_SHORT;
                        end
                    end else if (w_line_full || i_end) begin
                        o_res_valid      = 1'b1;
                        o_res.error_code = ERR_LINE;
                    end
                end
                PH_PAYLOAD: begin
                    o_res_valid = 1'b1;
                    if (w_frame_done) begin
                        o_res.out_kind       = KIND_PAYLOAD;
                        o_res.payload_byte   = i_byte;
                        o_res.frame_last     = 1'b1;
                        o_res.payload_length = r_len[LEN_W-1:0];
                    end else if (i_end) begin
                        o_res.error_code = ERR_SHORT;
                    end else begin
                        o_res.out_kind     = KIND_PAYLOAD;
                        o_res.payload_byte = i_byte;
                    end
                end
                default: begin
                    o_res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_PREFIX;
            r_pos        <= '0;
            r_line_chars <= '0;
            r_len        <= '0;
            r_pcount     <= '0;
        end else begin
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_line_chars <= n_line_chars;
            r_len        <= n_len;
            r_pcount     <= n_pcount;
        end
    end

    // request end always returns to a clean prefix search
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_end |=> r_phase == PH_PREFIX && r_pos == '0 && r_len == '0)
        else $error("request end did not clear parse state");

    // payload phase only ever holds an accepted length
    a_payload_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_len != '0 && r_len[ACC_W-1] == 1'b0)
        else $error("payload phase with length out of range");

    // the payload counter never reaches the length while still in payload phase
    a_payload_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> {1'b0, r_pcount} < r_len)
        else $error("payload counter overran declared length");

endmodule

>>> hw/rtl/length_prefixed_command_deframer.sv
// top level of the length-prefixed command deframer: stream ports,
// configuration registers, input and result registers; depends on lpcd_pkg, lpcd_core
//
// Takes a request one byte per cycle on the slave stream (tlast marks the final byte),
// checks it against the configured ASCII prefix, reads a decimal length line ended by
// CR or LF, then passes that many payload bytes out on the master stream; the last one
// has tlast set and carries the length. Errors go out once as an error report (tuser 1)
// and the rest of the request is dropped. Every byte passes through one input register
// and one result register, and a new byte is taken every cycle; the only limit is the
// master side holding a result, which stalls the input register and then the slave side.
// Configuration must be written only while idle; the block itself does not enforce it.
module length_prefixed_command_deframer #(
    parameter int LINE_CHARS_MAX = 31
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [lpcd_pkg::CIDX_W-1:0]      i_cfg_index,
    input  logic [lpcd_pkg::PTEXT_W-1:0]     i_cfg_data,
    // request byte stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [7:0]                       i_s_tdata,   // [7:0] data_byte
    input  logic                             i_s_tlast,   // request_end
    // result stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [7:0] payload_byte, [23:8] payload_length, [25:24] error_code, [31:26] zero
    output logic [lpcd_pkg::MDATA_W-1:0]     o_m_tdata,
    output logic                             o_m_tuser,   // out_kind
    output logic                             o_m_tlast    // frame_last
);
    import lpcd_pkg::*;

    // configuration registers
    t_cfg              r_cfg;

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_end;

    // result register
    logic              r_o_valid;
    t_result           r_o;

    logic              w_out_room;
    logic              w_fire;
    logic              w_res_valid;
    t_result           w_res;

    // the byte in the input register is processed once the result register can take it
    assign w_out_room = !r_o_valid || i_m_tready;
    assign w_fire     = r_in_valid && w_out_room;
    assign o_s_tready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prefix_text  <= PREFIX_TEXT_RST;
            r_cfg.prefix_count <= PREFIX_COUNT_RST;
            r_cfg.max_length   <= MAX_LENGTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PREFIX_TEXT:  r_cfg.prefix_text  <= i_cfg_data;
                CFG_PREFIX_COUNT: r_cfg.prefix_count <= i_cfg_data[PCOUNT_W-1:0];
                CFG_MAX_LENGTH:   r_cfg.max_length   <= i_cfg_data[LEN_W-1:0];
                default: begin
                    // unused index, write ignored
                end
            endcase
        end
    end

    // input register takes a request byte whenever it is empty or draining
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
            r_in_end  <= i_s_tlast;
        end
    end

    lpcd_core #(
        .LINE_CHARS_MAX (LINE_CHARS_MAX)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_fire      (w_fire),
        .i_byte      (r_in_byte),
        .i_end       (r_in_end),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // result register; a byte with no result just clears it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_fire) begin
            r_o_valid <= w_res_valid;
        end else if (i_m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_o <= w_res;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tuser  = r_o.out_kind;
    assign o_m_tlast  = r_o.frame_last;
    assign o_m_tdata  = {6'd0, r_o.error_code, r_o.payload_length, r_o.payload_byte};

    // a waiting byte keeps its contents until processed
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_fire |=> r_in_valid && $stable(r_in_byte) && $stable(r_in_end))
        else $error("input register lost a waiting byte");

    // processing never overwrites a result that was not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |-> !r_o_valid || i_m_tready)
        else $error("result register overwritten while stalled");

    // error reports never carry payload or frame end
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o.out_kind == KIND_ERROR |-> !r_o.frame_last && r_o.payload_byte == '0)
        else $error("error report carries payload fields");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for length_prefixed_command_deframer: a clocked driver and monitor
// around the block, with a bit-exact predictor of the deframer; depends on lpcd_pkg and the deframer
module testbench;
    import lpcd_pkg::*;

    localparam int LINE_MAX         = 31;
    localparam int N_SETTINGS       = 7;
    localparam int RAND_PER_SETTING = 86;  // random byte requests per configuration
    localparam int DRAIN_CYCLES     = 4;   // margin after the input and result registers
    localparam int MAX_REPORTS      = 20;
    localparam int TIMEOUT_NS       = 400000;

    // no register sits at this index, so a write there must change nothing
    localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              fin;
    } t_byte_req;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic [CIDX_W-1:0]   i_cfg_index = '0;
    logic [PTEXT_W-1:0]  i_cfg_data  = '0;
    logic                i_s_tvalid  = 1'b0;
    logic [7:0]          i_s_tdata   = '0;
    logic                i_s_tlast   = 1'b0;
    logic                i_m_tready  = 1'b0;
    logic                o_s_tready;
    logic                o_m_tvalid;
    logic [MDATA_W-1:0]  o_m_tdata;
    logic                o_m_tuser;
    logic                o_m_tlast;

    // predictor copy of the configuration registers
    logic [PTEXT_W-1:0]  cfg_text  = PREFIX_TEXT_RST;
    logic [PCOUNT_W-1:0] cfg_count = PREFIX_COUNT_RST;
    logic [LEN_W-1:0]    cfg_max   = MAX_LENGTH_RST;

    // predictor copy of the parsing state
    t_phase              dec_phase   = PH_PREFIX;
    logic [3:0]          dec_pfx_pos = '0;
    logic [4:0]          dec_line_n  = '0;
    logic [ACC_W-1:0]    dec_len     = '0;
    logic [LEN_W-1:0]    dec_pay_n   = '0;

    t_byte_req           byte_req_q[$];  // bytes waiting for the driver
    t_result             deframed_q[$];  // predicted results, oldest first
    logic [7:0]          cmd_q[$];       // command under construction

    int                  pushed_n       = 0;
    int                  accepted_n     = 0;
    int                  result_n       = 0;
    int                  mismatch_n     = 0;
    int                  send_idle_pct  = 15;
    int                  recv_stall_pct = 52;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    length_prefixed_command_deframer #(
        .LINE_CHARS_MAX(LINE_MAX)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    function automatic t_result error_report(input logic [CODE_W-1:0] code);
        t_result res;
        res = '0;
        res.out_kind   = KIND_ERROR;
        res.error_code = code;
        return res;
    endfunction

    // advance the deframer by one byte; returns 1 when the byte yields a result
    function automatic bit deframe_byte(input logic [7:0] b, input logic fin,
                                        output t_result res);
        logic [3:0]  pc;
        logic [63:0] shifted;
        logic [31:0] acc;
        bit          hit;
        hit = 1'b0;
        res = '0;
        // counts above eight act as eight
        pc = (cfg_count > PREFIX_COUNT_MAX) ? PREFIX_COUNT_MAX : cfg_count;
        // empty prefix, or one shortened by a register write: go straight to the line
        if (dec_phase == PH_PREFIX && dec_pfx_pos >= pc) begin
            dec_phase  = PH_LINE;
            dec_line_n = '0;
            dec_len    = '0;
        end
        case (dec_phase)
            PH_PREFIX: begin
                shifted = cfg_text >> (8 * (7 - dec_pfx_pos[2:0]));
                if (b != shifted[7:0]) begin
                    res = error_report(ERR_PREFIX);
                    hit = 1'b1;
                    dec_phase = PH_DISCARD;
                end else begin
                    dec_pfx_pos = dec_pfx_pos + 4'd1;
                    if (dec_pfx_pos >= pc) begin
                        dec_phase  = PH_LINE;
                        dec_line_n = '0;
                        dec_len    = '0;
                    end else if (fin) begin
                        // command ends inside the prefix
                        res = error_report(ERR_PREFIX);
                        hit = 1'b1;
                    end
                end
            end
            PH_LINE: begin
                if (b == CHAR_LF || b == CHAR_CR) begin
                    if (dec_len == '0 || dec_len >= {1'b0, cfg_max}) begin
                        res = error_report(ERR_RANGE);
                        hit = 1'b1;
                        dec_phase = PH_DISCARD;
                    end else begin
                        dec_phase = PH_PAYLOAD;
                        dec_pay_n = '0;
                        // a valid line with no payload after it
                        if (fin) begin
                            res = error_report(ERR_SHORT);
                            hit = 1'b1;
                        end
                    end
                end else if (dec_line_n >= LINE_MAX) begin
                    // overlong line
                    res = error_report(ERR_LINE);
                    hit = 1'b1;
                    dec_phase = PH_DISCARD;
                end else begin
                    dec_line_n = dec_line_n + 5'd1;
                    if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                        acc = {15'd0, dec_len} * 32'd10 + {24'd0, b} - {24'd0, CHAR_ZERO};
                        dec_len = (acc > {15'd0, LEN_SAT}) ? LEN_SAT : acc[ACC_W-1:0];
                    end
                    if (fin) begin
                        res = error_report(ERR_LINE);
                        hit = 1'b1;
                    end
                end
            end
            PH_PAYLOAD: begin
                dec_pay_n = dec_pay_n + 16'd1;
                if ({1'b0, dec_pay_n} >= dec_len) begin
                    res.out_kind       = KIND_PAYLOAD;
                    res.payload_byte   = b;
                    res.frame_last     = 1'b1;
                    res.payload_length = dec_len[LEN_W-1:0];
                    hit = 1'b1;
                    dec_phase = PH_DISCARD;
                end else if (fin) begin
                    // cut short: the report replaces this byte
                    res = error_report(ERR_SHORT);
                    hit = 1'b1;
                end else begin
                    res.out_kind     = KIND_PAYLOAD;
                    res.payload_byte = b;
                    hit = 1'b1;
                end
            end
            default: ;
        endcase
        if (fin) begin
            dec_phase   = PH_PREFIX;
            dec_pfx_pos = '0;
            dec_line_n  = '0;
            dec_len     = '0;
            dec_pay_n   = '0;
        end
        return hit;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_n++;
        if (mismatch_n <= MAX_REPORTS)
            $display("mismatch: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                      result_n, name, got, want));
    endtask

    // driver: one byte request per handshake, fed from byte_req_q
    always @(posedge i_clk) begin : drive_bytes
        t_result   res;
        t_byte_req req;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            // predict at the edge that accepts the byte
            if (i_s_tvalid && o_s_tready) begin
                if (deframe_byte(i_s_tdata, i_s_tlast, res))
                    deframed_q.push_back(res);
                accepted_n++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (byte_req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    req = byte_req_q.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= req.data;
                    i_s_tlast  <= req.fin;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : watch_results
        t_result want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (deframed_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no prediction, tdata %0h",
                                              result_n, o_m_tdata));
                end else begin
                    want = deframed_q.pop_front();
                    check_field("out_kind", 32'(o_m_tuser), 32'(want.out_kind));
                    check_field("payload_byte", 32'(o_m_tdata[7:0]),
                                32'(want.payload_byte));
                    check_field("frame_last", 32'(o_m_tlast), 32'(want.frame_last));
                    check_field("payload_length", 32'(o_m_tdata[23:8]),
                                32'(want.payload_length));
                    check_field("error_code", 32'(o_m_tdata[25:24]), 32'(want.error_code));
                    check_field("tdata padding", 32'(o_m_tdata[MDATA_W-1:26]), 32'd0);
                end
                result_n++;
            end
            i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // wait until every byte is taken and every predicted result has come out
    task automatic wait_drained();
        while (accepted_n != pushed_n || deframed_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [PTEXT_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_PREFIX_TEXT:  cfg_text  = data;
            CFG_PREFIX_COUNT: cfg_count = data[PCOUNT_W-1:0];
            CFG_MAX_LENGTH:   cfg_max   = data[LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            cmd_q.push_back(s[i]);
    endtask

    // queue cmd_q as one command, tlast on its final byte; hold_midway stops the
    // sender halfway until the block has fully drained
    task automatic send_command(input bit hold_midway);
        int        i;
        t_byte_req req;
        for (i = 0; i < cmd_q.size(); i++) begin
            if (hold_midway && i == cmd_q.size() / 2)
                wait_drained();
            req.data = cmd_q[i];
            req.fin  = (i == cmd_q.size() - 1);
            byte_req_q.push_back(req);
            pushed_n++;
        end
        cmd_q.delete();
    endtask

    // any byte that is neither a digit nor a line end
    function automatic logic [7:0] noise_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while ((c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_LF || c == CHAR_CR);
        return c;
    endfunction

    function automatic logic [7:0] payload_char();
        if ($urandom_range(0, 7) == 0)
            return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    // one random command, mostly well formed against the current configuration
    task automatic gen_command(input bit hold_midway);
        int unsigned pc, r, len, tmp, hi_ok, cap, n_pay, i, target, bad_pos, cut;
        logic [63:0] shifted;
        logic [7:0]  c;
        logic [7:0]  digit_q[$];
        logic [7:0]  line_q[$];
        bit          in_range;
        bit          saturate;
        pc = (cfg_count > PREFIX_COUNT_MAX) ? PREFIX_COUNT_MAX : cfg_count;
        r  = $urandom_range(0, 99);
        if (r < 6) begin
            // line noise, nothing like a command
            repeat ($urandom_range(1, 6)) cmd_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            bad_pos = (pc != 0) ? $urandom_range(0, pc - 1) : 0;
            for (i = 0; i < pc; i++) begin
                shifted = cfg_text >> (8 * (7 - i));
                c = shifted[7:0];
                if (r < 14 && i == bad_pos)
                    c = c ^ 8'($urandom_range(1, 255));
                cmd_q.push_back(c);
            end

            // length: mostly small and valid, some at the edges of the range
            hi_ok    = (cfg_max >= 2) ? cfg_max - 1 : 0;
            cap      = (hi_ok < 12) ? hi_ok : 12;
            saturate = 1'b0;
            r = $urandom_range(0, 99);
            if (cap == 0 && r < 86)
                r = 86 + r % 8;
            if (r < 70)
                len = $urandom_range(1, cap);
            else if (r < 78)
                len = 0;
            else if (r < 86 && hi_ok != 0 && hi_ok <= 64)
                len = hi_ok;
            else if (r < 94)
                len = cfg_max + $urandom_range(0, 3);
            else begin
                len = 0;
                saturate = 1'b1;
            end

            if (saturate) begin
                repeat ($urandom_range(7, 12)) digit_q.push_back(CHAR_NINE);
            end else begin
                tmp = len;
                do begin
                    digit_q.push_front(CHAR_ZERO + 8'(tmp % 10));
                    tmp = tmp / 10;
                end while (tmp != 0);
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 3)) digit_q.push_front(CHAR_ZERO);
            end

            // stray characters on the line are ignored
            for (i = 0; i < digit_q.size(); i++) begin
                if ($urandom_range(0, 4) == 0)
                    line_q.push_back(noise_char());
                line_q.push_back(digit_q[i]);
            end
            // pad to exactly the line limit or just past it
            if ($urandom_range(0, 19) == 0) begin
                target = $urandom_range(LINE_MAX, LINE_MAX + 3);
                while (line_q.size() < target)
                    line_q.push_front(noise_char());
            end
            for (i = 0; i < line_q.size(); i++)
                cmd_q.push_back(line_q[i]);
            cmd_q.push_back(($urandom_range(0, 1) != 0) ? CHAR_CR : CHAR_LF);

            in_range = !saturate && len != 0 && len < cfg_max;
            n_pay = in_range ? len : $urandom_range(0, 3);
            repeat (n_pay) cmd_q.push_back(payload_char());
            // trailing bytes after a complete frame
            if ($urandom_range(0, 6) == 0)
                repeat ($urandom_range(1, 3)) cmd_q.push_back(payload_char());
            // end the command early, anywhere in prefix, line or payload
            if ($urandom_range(0, 7) == 0) begin
                cut = $urandom_range(1, cmd_q.size());
                while (cmd_q.size() > cut)
                    cmd_q.delete(cmd_q.size() - 1);
            end
        end
        send_command(hold_midway);
    endtask

    initial begin : run_stimulus
        int               s;
        int               base;
        logic [63:0]      text;
        logic [3:0]       cnt;
        logic [15:0]      mx;
        bit               hold;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset configuration: a one-byte frame with a zero payload byte,
        // then a command that ends inside the prefix
        add_text("COMMAND:1\n");
        cmd_q.push_back(8'h00);
        send_command(1'b0);
        add_text("CO");
        send_command(1'b0);

        // directed, one-character prefix
        wait_drained();
        write_reg(CFG_PREFIX_COUNT, 64'd1);
        write_reg(CFG_PREFIX_TEXT, {8'h23, 56'd0});
        cmd_q.push_back(8'hFF);    // prefix mismatch
        send_command(1'b0);
        add_text("#5");            // ends inside the length line
        send_command(1'b0);
        add_text("#1\r");          // valid line ends the command
        send_command(1'b0);
        add_text("#3\nab");        // payload cut short
        send_command(1'b0);
        add_text("#1\nqr");        // byte after the frame is dropped
        send_command(1'b0);

        base = pushed_n;
        for (s = 0; s < N_SETTINGS; s++) begin
            wait_drained();
            case (s)
                0: begin
                    text = PREFIX_TEXT_RST; cnt = PREFIX_COUNT_RST; mx = MAX_LENGTH_RST;
                end
                1: begin
                    // no prefix, only length one passes
                    text = {$urandom, $urandom}; cnt = 4'd0; mx = 16'd2;
                end
                2: begin
                    text = {$urandom, $urandom}; cnt = 4'd1; mx = 16'hFFFF;
                end
                3: begin
                    // count beyond eight acts as eight
                    text = '1; cnt = 4'd15; mx = 16'd20;
                end
                4: begin
                    // every length rejected
                    text = '0; cnt = 4'd3; mx = 16'd1;
                end
                5: begin
                    text = {$urandom, $urandom}; cnt = 4'd4; mx = 16'd9;
                end
                default: begin
                    text = {$urandom, $urandom}; cnt = 4'd2; mx = 16'd300;
                end
            endcase
            write_reg(CFG_PREFIX_TEXT, text);
            write_reg(CFG_PREFIX_COUNT, {60'd0, cnt});
            write_reg(CFG_MAX_LENGTH, {48'd0, mx});
            if (s == 5)
                write_reg(CFG_UNUSED, {$urandom, $urandom});
            if (s <= 2) begin
                send_idle_pct = 15; recv_stall_pct = 52;
            end else if (s <= 4) begin
                send_idle_pct = 52; recv_stall_pct = 15;
            end else begin
                send_idle_pct = 0; recv_stall_pct = 0;
            end
            // in setting 2 one command pauses halfway until the block drains
            hold = (s == 2);
            while (pushed_n < base + (s + 1) * RAND_PER_SETTING) begin
                gen_command(hold);
                hold = 1'b0;
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_n == 0 && deframed_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> length_prefixed_command_deframer.f
hw/rtl/lpcd_pkg.sv
hw/rtl/lpcd_core.sv
hw/rtl/length_prefixed_command_deframer.sv
sim/testbench.sv
